// ===== rtl/arc_pkg.sv =====
package arc_pkg;

    // Received ARP header fields or a lookup query, one beat.
    typedef struct packed {
        logic        op;
        logic [10:0] payload_length;
        logic [15:0] hardware_type;
        logic [15:0] protocol_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } t_arc_in;

    // One result beat.
    typedef struct packed {
        logic        reply_valid;
        logic [15:0] reply_opcode;
        logic [47:0] reply_sender_mac;
        logic [31:0] reply_sender_ip;
        logic [47:0] reply_target_mac;
        logic [31:0] reply_target_ip;
        logic        cache_stored;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
    } t_arc_out;

    // Classified work passed from the front end to the back end.
    typedef logic [1:0] t_arc_kind;

    localparam t_arc_kind KIND_DROP   = 2'd0;
    localparam t_arc_kind KIND_REPLY  = 2'd1;
    localparam t_arc_kind KIND_STORE  = 2'd2;
    localparam t_arc_kind KIND_LOOKUP = 2'd3;

    typedef struct packed {
        t_arc_kind   kind;
        logic [47:0] mac;
        logic [31:0] ip;
    } t_arc_job;

    // Input operation codes.
    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_LOOKUP  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    // ARP header constants.
    localparam logic [10:0] MIN_ARP_BYTES  = 11'd28;
    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

endpackage

// ===== rtl/arp_responder_cache.sv =====
// Channel    | Ports                                | Handshake
// -----------+--------------------------------------+-------------------------------
// item in    | start, busy, i_item                  | beat taken when start && !busy
// result out | o_valid, o_result                    | one-cycle strobe, no back-pressure
// config     | i_cfg_we, i_cfg_idx, i_cfg_data      | written when i_cfg_we is high
//
// A reply, store or dropped message is held in the job queue and, once the back end is
// free, registered in the output register. A lookup instead starts a cache scan: the
// scan reads one cache entry per cycle from the registered-read RAM and stops at the
// first match. Two beats can wait in the job queue; busy rises while it is full.
// Reset is synchronous and active low; it empties the cache and clears own IP and MAC.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module arp_responder_cache #(
    parameter int CACHE_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  arc_pkg::t_arc_in  i_item,
    output logic              o_valid,
    output arc_pkg::t_arc_out o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [47:0]       i_cfg_data
);

    logic [31:0]       r_own_ip;
    logic [47:0]       r_own_mac;
    logic              job_vld;
    arc_pkg::t_arc_job job;
    logic              pop;

    // Station address registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arc_pkg::CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                arc_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    arc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_own_ip  (r_own_ip),
        .i_pop     (pop),
        .o_job_vld (job_vld),
        .o_job     (job)
    );

    arc_back #(.CACHE_DEPTH(CACHE_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (job_vld),
        .i_job     (job),
        .o_pop     (pop),
        .i_own_ip  (r_own_ip),
        .i_own_mac (r_own_mac),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

// ===== rtl/arc_ram.sv =====
module arc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/arc_front.sv =====
module arc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  arc_pkg::t_arc_in i_item,
    input  logic [31:0]      i_own_ip,
    input  logic             i_pop,
    output logic             o_job_vld,
    output arc_pkg::t_arc_job o_job
);

    arc_pkg::t_arc_job r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              n_wp;
    logic              n_rp;
    logic [1:0]        n_cnt;
    logic              push;
    logic              msg_ok;
    arc_pkg::t_arc_job job;

    // A message qualifies when it is a full Ethernet/IPv4 ARP aimed at us.
    assign msg_ok = (i_item.payload_length >= arc_pkg::MIN_ARP_BYTES)
                 && (i_item.hardware_type  == arc_pkg::HTYPE_ETHERNET)
                 && (i_item.protocol_type  == arc_pkg::PTYPE_IPV4)
                 && (i_item.hw_addr_len    == arc_pkg::HLEN_ETHERNET)
                 && (i_item.proto_addr_len == arc_pkg::PLEN_IPV4)
                 && (i_item.target_ip      == i_own_ip);

    // Classify the incoming beat into a job for the back end.
    always_comb begin
        job.mac  = i_item.sender_mac;
        job.ip   = i_item.sender_ip;
        job.kind = arc_pkg::KIND_DROP;
        if (i_item.op == arc_pkg::OP_LOOKUP) begin
            job.kind = arc_pkg::KIND_LOOKUP;
            job.ip   = i_item.query_ip;
        end else if (msg_ok && i_item.opcode == arc_pkg::ARP_OP_REQUEST) begin
            job.kind = arc_pkg::KIND_REPLY;
        end else if (msg_ok && i_item.opcode == arc_pkg::ARP_OP_REPLY) begin
            job.kind = arc_pkg::KIND_STORE;
        end
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy;

    // Two-entry job queue pointer update.
    always_comb begin
        n_wp  = push  ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    assign o_job_vld = (r_cnt != 2'd0);
    assign o_job     = r_q[r_rp];

    // The back end only takes a job that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("job popped from an empty queue");

    // The occupancy never exceeds the two slots.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("job queue overflow");

    // A beat taken while one job is waiting and none leaves fills the queue.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop && r_cnt == 2'd1) |=> busy)
        else $error("queue did not report full");

endmodule

// ===== rtl/arc_back.sv =====
module arc_back #(
    parameter int CACHE_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_vld,
    input  arc_pkg::t_arc_job i_job,
    output logic              o_pop,
    input  logic [31:0]       i_own_ip,
    input  logic [47:0]       i_own_mac,
    output logic              o_valid,
    output arc_pkg::t_arc_out o_result
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              r_state;
    logic              n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_addr;
    logic [CW-1:0]     n_addr;
    logic              r_pend;
    logic              n_pend;
    logic [31:0]       r_qip;
    logic [31:0]       n_qip;
    logic              r_out_vld;
    logic              n_out_vld;
    arc_pkg::t_arc_out r_out;
    arc_pkg::t_arc_out n_out;
    logic              wr_en;
    logic [31:0]       rd_ip;
    logic [47:0]       rd_mac;
    logic              hit;

    // Cache tables, appended at the fill count and scanned from the oldest.
    arc_ram #(.WIDTH(32), .DEPTH(CACHE_DEPTH)) u_ip_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_job.ip),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_ip)
    );

    arc_ram #(.WIDTH(48), .DEPTH(CACHE_DEPTH)) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_job.mac),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_mac)
    );

    // The entry read last cycle matches the queried address.
    assign hit = r_pend && (rd_ip == r_qip);

    // Job execution and scan sequencing.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_pend    = 1'b0;
        n_qip     = r_qip;
        n_out_vld = 1'b0;
        n_out     = r_out;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    o_pop = 1'b1;
                    n_out = '0;
                    case (i_job.kind)
                        arc_pkg::KIND_REPLY: begin
                            n_out_vld              = 1'b1;
                            n_out.reply_valid      = 1'b1;
                            n_out.reply_opcode     = arc_pkg::ARP_OP_REPLY;
                            n_out.reply_sender_mac = i_own_mac;
                            n_out.reply_sender_ip  = i_own_ip;
                            n_out.reply_target_mac = i_job.mac;
                            n_out.reply_target_ip  = i_job.ip;
                        end
                        arc_pkg::KIND_STORE: begin
                            n_out_vld = 1'b1;
                            if (r_count < CW'(CACHE_DEPTH)) begin
                                wr_en              = 1'b1;
                                n_count            = r_count + 1'b1;
                                n_out.cache_stored = 1'b1;
                            end
                        end
                        arc_pkg::KIND_LOOKUP: begin
                            n_state = S_SCAN;
                            n_addr  = '0;
                            n_qip   = i_job.ip;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_out_vld        = 1'b1;
                    n_out.lookup_hit = 1'b1;
                    n_out.lookup_mac = rd_mac;
                    n_state          = S_IDLE;
                end else if (r_addr == r_count) begin
                    n_out_vld        = 1'b1;
                    n_out.lookup_hit = 1'b0;
                    n_out.lookup_mac = arc_pkg::MAC_BROADCAST;
                    n_state          = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_qip <= n_qip;
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // The fill count never passes the cache depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CACHE_DEPTH))
        else $error("cache fill count beyond depth");

    // The scan pointer stays within the filled entries.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_count))
        else $error("scan pointer beyond fill count");

    // The fill count moves only with a stored strobe.
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_out_vld && r_out.cache_stored))
        else $error("fill count changed without a store");

    // A hit always reports a stored address, never a reply.
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.lookup_hit) |-> !r_out.reply_valid && !r_out.cache_stored)
        else $error("lookup hit mixed with message result");

endmodule
